// ===== hw/rtl/binary_to_decimal_ascii_top_assert.svh =====
// Assertion macros shared by the block's checker.
// Each macro expands to one labeled concurrent assertion.
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// Antecedent at one edge implies the consequent at the next edge.
`define BDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bda: next-cycle check failed");

// Antecedent implies the consequent in the same cycle.
`define BDA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bda: same-cycle check failed");

`endif

// ===== hw/rtl/bda_pkg.sv =====
// ---------------------------------------------------------------------------
// bda_pkg
// Shared types and constants of the binary to decimal ASCII converter.
// ---------------------------------------------------------------------------
`default_nettype none

package bda_pkg;

    localparam int BIN_WIDTH   = 32;
    localparam int STEP_W      = $clog2(BIN_WIDTH);
    localparam int DIGIT_WIDTH = 4;
    localparam int CHAR_WIDTH  = 6;

    localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 6'd48;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;       // capture a new value, clear BCD register
        logic step;       // one shift-and-adjust iteration
        logic shift_out;  // drop the digit just transferred
    } t_dp_cmd;

endpackage

`default_nettype wire

// ===== hw/rtl/bda_datapath.sv =====
// ---------------------------------------------------------------------------
// bda_datapath
// Double dabble shift register and digit output register.
// ---------------------------------------------------------------------------
`default_nettype none

module bda_datapath
    import bda_pkg::*;
#(
    parameter int NUM_DIGITS = 11
) (
    input  wire logic                  i_clk,
    input  wire t_dp_cmd               i_cmd,
    input  wire logic [BIN_WIDTH-1:0]  i_value,
    output logic      [CHAR_WIDTH-1:0] o_ascii_char
);

    localparam int BCD_W = NUM_DIGITS * DIGIT_WIDTH;

    logic [BIN_WIDTH-1:0] r_bin;
    logic [BIN_WIDTH-1:0] n_bin;
    logic [BCD_W-1:0]     r_bcd;
    logic [BCD_W-1:0]     n_bcd;
    logic [BCD_W-1:0]     adj_bcd;

    // Add 3 to every digit of 5 or more, digits are independent.
    always_comb begin
        logic [DIGIT_WIDTH-1:0] d;
        for (int g = 0; g < NUM_DIGITS; g++) begin
            d = r_bcd[g*DIGIT_WIDTH +: DIGIT_WIDTH];
            adj_bcd[g*DIGIT_WIDTH +: DIGIT_WIDTH] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        if (i_cmd.load) begin
            n_bin = i_value;
            n_bcd = '0;
        end else if (i_cmd.step) begin
            n_bin = {r_bin[BIN_WIDTH-2:0], 1'b0};
            n_bcd = {adj_bcd[BCD_W-2:0], r_bin[BIN_WIDTH-1]};
        end else if (i_cmd.shift_out) begin
            n_bcd = {r_bcd[BCD_W-DIGIT_WIDTH-1:0], {DIGIT_WIDTH{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_ascii_char = ASCII_ZERO
                        + {2'b00, r_bcd[BCD_W-1 -: DIGIT_WIDTH]};

endmodule

`default_nettype wire

// ===== hw/rtl/bda_ctrl.sv =====
// ---------------------------------------------------------------------------
// bda_ctrl
// Sequencer: accept, 32 conversion steps, then one transfer per digit.
// ---------------------------------------------------------------------------
`default_nettype none

module bda_ctrl
    import bda_pkg::*;
#(
    parameter int NUM_DIGITS = 11
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire logic i_stall,
    output t_dp_cmd   o_cmd,
    output logic      o_busy,
    output logic      o_valid,
    output logic      o_last
);

    localparam int POS_W = $clog2(NUM_DIGITS);
    localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(NUM_DIGITS - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(BIN_WIDTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;
    logic [POS_W-1:0]  r_pos;
    logic              r_valid;
    logic              r_last;
    logic              take_in;
    logic              take_out;

    assign take_in  = (r_state == S_IDLE) && i_valid;
    assign take_out = r_valid && !i_stall;

    assign o_cmd.load      = take_in;
    assign o_cmd.step      = (r_state == S_CONV);
    assign o_cmd.shift_out = take_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_pos   <= '0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_CONV;
                        r_step  <= '0;
                    end
                end
                S_CONV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST_STEP) begin
                        r_state <= S_EMIT;
                        r_pos   <= '0;
                        r_valid <= 1'b1;
                        r_last  <= 1'b0;
                    end
                end
                S_EMIT: begin
                    if (take_out) begin
                        if (r_pos == LAST_POS) begin
                            r_state <= S_IDLE;
                            r_valid <= 1'b0;
                            r_last  <= 1'b0;
                        end else begin
                            r_pos  <= r_pos + 1'b1;
                            r_last <= (r_pos + 1'b1) == LAST_POS;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_valid <= 1'b0;
                    r_last  <= 1'b0;
                end
            endcase
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_last  = r_last;

endmodule

`default_nettype wire

// ===== hw/rtl/binary_to_decimal_ascii_top.sv =====
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii_top
// Unsigned 32-bit binary to NUM_DIGITS ASCII decimal characters.
// ---------------------------------------------------------------------------
// One 32-bit value is taken on the input channel and converted by a double
// dabble shift-and-add-3 loop, one binary bit per cycle. The result then
// leaves as NUM_DIGITS ASCII characters, most significant first with leading
// zeros kept ('0' always leads with the default of eleven), one transfer per
// cycle while i_stall is low; o_last marks the least significant digit. One
// value occupies the block through the input transfer, the shift loop of the
// datapath and the digit-by-digit output, so a new value is taken only after
// the last digit of the previous one has left. o_stall stays high from the
// input transfer until the last digit has been transferred.
`default_nettype none

module binary_to_decimal_ascii_top
    import bda_pkg::*;
#(
    parameter int NUM_DIGITS = 11   // 10 to 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_value,
    // output channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [5:0]  o_ascii_char,
    output logic             o_last
);

    t_dp_cmd cmd;   // sequencer commands into the datapath
    logic    busy;

    // Sequencer: owns the step and digit counters and both handshakes.
    bda_ctrl #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_last  (o_last)
    );

    // Datapath: binary shift register, BCD register, ASCII offset.
    bda_datapath #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_value      (i_value),
        .o_ascii_char (o_ascii_char)
    );

    // New values are refused for the whole conversion and output run.
    assign o_stall = busy;

endmodule

`default_nettype wire

// ===== hw/rtl/bda_checker.sv =====
// ---------------------------------------------------------------------------
// bda_checker
// Port-level assertions for binary_to_decimal_ascii_top.
// ---------------------------------------------------------------------------
`default_nettype none

`include "binary_to_decimal_ascii_top_assert.svh"

module bda_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic [31:0] i_value,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [5:0]  o_ascii_char,
    input wire logic        o_last
);

    logic [6:0] out_item;
    logic       digit_ok;

    assign out_item = {o_ascii_char, o_last};
    assign digit_ok = (o_ascii_char >= 6'd48) && (o_ascii_char <= 6'd57);

    // A stalled digit holds.
    `BDA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(out_item))

    // Every digit shown is an ASCII decimal digit.
    `BDA_ASSERT_SAME(a_digit_range, i_clk, i_rst_n, o_valid, digit_ok)

    // No new value is taken while digits are still going out.
    `BDA_ASSERT_SAME(a_busy_emit, i_clk, i_rst_n, o_valid, o_stall)

    // An input transfer starts a conversion: no output yet, input closed.
    `BDA_ASSERT_NEXT(a_start_conv, i_clk, i_rst_n, i_valid && !o_stall, o_stall && !o_valid)

endmodule

bind binary_to_decimal_ascii_top bda_checker u_bda_checker (.*);

`default_nettype wire

// ===== tb/binary_to_decimal_ascii_top_test.sv =====
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii_top_test
// Self-checking bench for the binary to decimal ASCII converter.
// ---------------------------------------------------------------------------
// Values go in on the valid/stall input channel. Each accepted value is turned
// into its eleven expected ASCII digits by a local divide-by-ten predictor.
// Every character that leaves the block is checked in order against them:
// digit code and last flag. A short directed set covers the extremes and the
// digit boundaries. A random set follows, mixing small, boundary and
// full-range values. Both channels idle at random. Once, the output side
// holds off for a long stretch, so the converter backs up into its input.
// ---------------------------------------------------------------------------

module binary_to_decimal_ascii_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_DIGITS       = 11;
    localparam int RANDOM_VALUES    = 320;
    localparam int MAX_GAP          = 8;
    localparam int LONG_HOLD_AT     = 150;   // characters seen before the long hold-off
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 80;    // > one full conversion plus output
    localparam int MAX_REPORTS      = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_value;
    logic        o_valid;
    logic        i_stall;
    logic [5:0]  o_ascii_char;
    logic        o_last;

    // -----------------------------------------------------------------------
    // Scoreboard: predicts the decimal text of each accepted value and checks
    // the characters against it, oldest first.
    // -----------------------------------------------------------------------
    class DecimalTextScoreboard;
        typedef struct packed {
            logic [5:0] code;
            logic       last;
        } t_dec_char;

        t_dec_char pending_chars[$];
        int        failures;

        function void note_value(logic [31:0] value);
            logic [3:0]  digits[NUM_DIGITS];
            logic [31:0] rest;
            t_dec_char   c;
            rest = value;
            // least significant position last; positions beyond ten digits get 0
            for (int pos = NUM_DIGITS - 1; pos >= 0; pos--) begin
                digits[pos] = 4'(rest % 10);
                rest        = rest / 10;
            end
            for (int pos = 0; pos < NUM_DIGITS; pos++) begin
                c.code = bda_pkg::ASCII_ZERO + 6'(digits[pos]);
                c.last = (pos == NUM_DIGITS - 1);
                pending_chars.push_back(c);
            end
        endfunction

        function void check_char(logic [5:0] code, logic last);
            t_dec_char want;
            if (pending_chars.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%t: character with nothing pending: code %0d last %b",
                             $realtime, code, last);
                return;
            end
            want = pending_chars.pop_front();
            if (code !== want.code || last !== want.last) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%t: mismatch: expected code %0d last %b, got code %0d last %b",
                             $realtime, want.code, want.last, code, last);
            end
        endfunction

        function int outstanding();
            return pending_chars.size();
        endfunction
    endclass

    DecimalTextScoreboard board = new;

    bit          no_idle;        // burst mode: neither side idles
    int          chars_seen;
    int unsigned pow10[10];

    binary_to_decimal_ascii_top #(
        .NUM_DIGITS  (NUM_DIGITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_ascii_char (o_ascii_char),
        .o_last       (o_last)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Idle cycles before the next transfer; zero throughout a burst stretch.
    function automatic int pick_gap();
        if (no_idle)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Offer one value after an idle gap and hold it until the block takes it.
    // Inputs change only at the falling edge; valid stays high across
    // back-to-back transfers.
    task automatic send_value(input logic [31:0] value, input int gap);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_value = value;
        do
            @(posedge i_clk);
        while (o_stall);
        board.note_value(value);
        @(negedge i_clk);
    endtask

    // Random value, weighted toward small numbers and digit-count boundaries.
    function automatic logic [31:0] pick_value();
        int k;
        k = $urandom_range(1, 9);
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 99);
            1: return $urandom_range(0, 99999);
            2: return pow10[k] - 32'($urandom_range(0, 1));
            3: return $urandom_range(32'hF000_0000, 32'hFFFF_FFFF);
            default: return $urandom();
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Output side: checks every character transfer and stalls at random.
    // The long hold-off is counted here, while the input side keeps offering.
    // -----------------------------------------------------------------------
    initial begin : output_side
        int wait_left;
        int hold_left;
        bit took;
        wait_left = 0;
        hold_left = 0;
        chars_seen = 0;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            took = o_valid && !i_stall;
            if (took) begin
                board.check_char(o_ascii_char, o_last);
                chars_seen++;
                if (chars_seen == LONG_HOLD_AT)
                    hold_left = LONG_HOLD_CYCLES;
                wait_left = pick_gap();
            end
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_stall = 1'b1;
                hold_left--;
            end else if (wait_left > 0) begin
                i_stall = 1'b1;
                wait_left--;
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Input side: reset, directed values, random values, then drain.
    // -----------------------------------------------------------------------
    initial begin : input_side
        logic [31:0] directed[$];
        pow10[0] = 1;
        for (int i = 1; i < 10; i++)
            pow10[i] = pow10[i-1] * 10;

        i_valid = 1'b0;
        i_value = '0;
        i_rst_n = 1'b0;
        no_idle = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // extremes, digit-count boundaries, alternating bit patterns
        directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
                     32'd99999, 32'd100000, 32'd999999999, 32'd1000000000,
                     32'd1234567890, 32'd2147483647, 32'd2147483648,
                     32'd3999999999, 32'd4000000000, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'd4294967294, 32'd4294967295};
        foreach (directed[i])
            send_value(directed[i], (i < 8) ? 0 : $urandom_range(0, MAX_GAP));

        // random part in stretches; some stretches run with no idling at all
        for (int n = 0; n < RANDOM_VALUES; n++) begin
            if (n % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_value(pick_value(), pick_gap());
        end
        no_idle = 1'b0;
        i_valid = 1'b0;

        while (board.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Ends the run as failed if it hangs; the limit lies far above the worst case.
    initial begin : watchdog
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
